// ===== rtl/core/b64c_pkg.sv =====
// ----------------------------------------------------------------------------
// Base64 codec package
// Job descriptor passed from the front end to the back end, alphabet helpers.
// ----------------------------------------------------------------------------
package b64c_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    localparam logic [7:0] CHAR_PAD   = 8'h3D;  // '='
    localparam logic [6:0] VAL_PAD    = 7'd64;
    localparam logic [6:0] VAL_SKIP   = 7'd65;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    typedef enum logic [1:0] {
        K_ENC  = 2'd0,  // four characters, trailing ones may be '='
        K_DEC  = 2'd1,  // one to three decoded bytes
        K_TERM = 2'd2   // single terminator without data
    } t_kind;

    typedef struct packed {
        logic [23:0] bits;
        t_kind       kind;
        logic [2:0]  cnt;   // results in this job, 1..4
        logic [1:0]  npad;  // trailing '=' characters (encode)
        logic        bad;   // terminator flags a broken decode group
        logic        last;  // final result closes the message
    } t_job;

    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (v < 6'd26)       return 8'(8'd65 + w);
        else if (v < 6'd52)  return 8'(8'd97 + w - 8'd26);
        else if (v < 6'd62)  return 8'(8'd48 + w - 8'd52);
        else if (v == 6'd62) return 8'h2B;
        else                 return 8'h2F;
    endfunction

    // 6-bit value, VAL_PAD for '=', VAL_SKIP for anything outside the alphabet
    function automatic logic [6:0] char_value(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A)      return 7'(c - 8'h41);
        else if (c >= 8'h61 && c <= 8'h7A) return 7'(c - 8'h61 + 8'd26);
        else if (c >= 8'h30 && c <= 8'h39) return 7'(c - 8'h30 + 8'd52);
        else if (c == 8'h2B)               return 7'd62;
        else if (c == 8'h2F)               return 7'd63;
        else if (c == CHAR_PAD)            return VAL_PAD;
        else                               return VAL_SKIP;
    endfunction

endpackage

// ===== rtl/core/b64c_front.sv =====
// ----------------------------------------------------------------------------
// Base64 codec front end
// Accepts one byte per cycle while the job queue has room, tracks the current
// group and issues one job per group that yields data, or per message end.
// ----------------------------------------------------------------------------
module b64c_front
    import b64c_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_mode_we,
    input  logic        i_mode_wdata,
    input  logic        i_valid,
    input  logic [7:0]  i_data,
    input  logic        i_last,
    input  logic        i_full,
    output logic        o_ready,
    output logic        o_push,
    output t_job        o_job
);

    logic        r_mode;
    logic [1:0]  r_phase;
    logic [23:0] r_held;
    logic [1:0]  r_pad;

    logic [1:0]  n_phase;
    logic [23:0] n_held;
    logic [1:0]  n_pad;
    logic        job_valid;
    logic        accept;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    assign o_push  = accept && job_valid;

    always_comb begin
        logic [6:0] v;
        logic [5:0] v6;
        logic [1:0] nbytes;
        n_phase   = r_phase;
        n_held    = r_held;
        n_pad     = r_pad;
        job_valid = 1'b0;
        o_job     = '0;
        o_job.kind = K_ENC;
        v      = char_value(i_data);
        v6     = v[5:0];
        nbytes = 2'd0;
        if (r_mode == MODE_ENCODE) begin
            n_held  = {r_held[15:0], i_data};
            n_phase = 2'(r_phase + 2'd1);
            if (n_phase == 2'd3) begin
                job_valid  = 1'b1;
                o_job.bits = n_held;
                o_job.cnt  = 3'd4;
                o_job.last = i_last;
                n_phase = '0;
                n_held  = '0;
            end else if (i_last) begin
                job_valid  = 1'b1;
                o_job.cnt  = 3'd4;
                o_job.last = 1'b1;
                if (n_phase == 2'd1) begin
                    o_job.bits = {n_held[7:0], 16'h0000};
                    o_job.npad = 2'd2;
                end else begin
                    o_job.bits = {n_held[15:0], 8'h00};
                    o_job.npad = 2'd1;
                end
                n_phase = '0;
                n_held  = '0;
            end
        end else begin
            if (v != VAL_SKIP) begin
                if (v == VAL_PAD) begin
                    v6 = '0;
                    if (r_pad != 2'd3) n_pad = 2'(r_pad + 2'd1);
                end
                n_held = {r_held[17:0], v6};
                if (r_phase == 2'd3) begin
                    nbytes = 2'(2'd3 - n_pad);
                    if (nbytes != 2'd0) begin
                        job_valid  = 1'b1;
                        o_job.kind = K_DEC;
                        o_job.bits = n_held;
                        o_job.cnt  = {1'b0, nbytes};
                        o_job.last = i_last;
                    end
                    n_phase = '0;
                    n_held  = '0;
                    n_pad   = '0;
                end else begin
                    n_phase = 2'(r_phase + 2'd1);
                end
            end
            if (i_last) begin
                if (n_phase != 2'd0) begin
                    // message ended inside a group: flag it and drop the group
                    job_valid  = 1'b1;
                    o_job      = '0;
                    o_job.kind = K_TERM;
                    o_job.cnt  = 3'd1;
                    o_job.bad  = 1'b1;
                    o_job.last = 1'b1;
                    n_phase = '0;
                    n_held  = '0;
                    n_pad   = '0;
                end else if (!job_valid) begin
                    job_valid  = 1'b1;
                    o_job      = '0;
                    o_job.kind = K_TERM;
                    o_job.cnt  = 3'd1;
                    o_job.last = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_ENCODE;
            r_phase <= '0;
            r_held  <= '0;
            r_pad   <= '0;
        end else if (i_mode_we) begin
            r_mode  <= i_mode_wdata;
            r_phase <= '0;
            r_held  <= '0;
            r_pad   <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_held  <= n_held;
            r_pad   <= n_pad;
        end
    end

endmodule

// ===== rtl/core/b64c_queue.sv =====
// ----------------------------------------------------------------------------
// Base64 codec job queue
// Short FIFO of job descriptors between front end and back end.
// ----------------------------------------------------------------------------
module b64c_queue
    import b64c_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_job o_job
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : PW'(r_wr + 1'b1);
            if (do_pop)  r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : PW'(r_rd + 1'b1);
            if (do_push && !do_pop)      r_cnt <= CW'(r_cnt + 1'b1);
            else if (do_pop && !do_push) r_cnt <= CW'(r_cnt - 1'b1);
        end
    end

endmodule

// ===== rtl/core/b64c_back.sv =====
// ----------------------------------------------------------------------------
// Base64 codec back end
// Expands each job into its result transactions, one per cycle unless the
// receiver stalls, into an output register.
// ----------------------------------------------------------------------------
module b64c_back
    import b64c_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_job       i_job,
    output logic       o_pop,
    output logic       o_tvalid,
    input  logic       i_tready,
    output logic [7:0] o_tdata,
    output logic [1:0] o_tuser,
    output logic       o_tlast
);

    logic       r_tvalid;
    logic [7:0] r_tdata;
    logic [1:0] r_tuser;
    logic       r_tlast;
    logic [1:0] r_idx;

    logic       load;
    logic       final_res;
    logic [7:0] n_tdata;
    logic [1:0] n_tuser;
    logic       n_tlast;

    assign load      = i_valid && (!r_tvalid || i_tready);
    assign final_res = ({1'b0, r_idx} == 3'(i_job.cnt - 3'd1));
    assign o_pop     = load && final_res;

    always_comb begin
        logic [5:0] sx;
        case (r_idx)
            2'd0:    sx = i_job.bits[23:18];
            2'd1:    sx = i_job.bits[17:12];
            2'd2:    sx = i_job.bits[11:6];
            default: sx = i_job.bits[5:0];
        endcase
        n_tlast = final_res && i_job.last;
        case (i_job.kind)
            K_ENC: begin
                n_tuser = 2'b01;
                if ({1'b0, r_idx} >= 3'(3'd4 - {1'b0, i_job.npad})) n_tdata = CHAR_PAD;
                else n_tdata = sextet_char(sx);
            end
            K_DEC: begin
                n_tuser = 2'b01;
                case (r_idx)
                    2'd0:    n_tdata = i_job.bits[23:16];
                    2'd1:    n_tdata = i_job.bits[15:8];
                    default: n_tdata = i_job.bits[7:0];
                endcase
            end
            default: begin
                n_tuser = {i_job.bad, 1'b0};
                n_tdata = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_tdata <= n_tdata;
            r_tuser <= n_tuser;
            r_tlast <= n_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tvalid <= 1'b0;
            r_idx    <= '0;
        end else begin
            if (load) begin
                r_tvalid <= 1'b1;
                r_idx    <= final_res ? '0 : 2'(r_idx + 2'd1);
            end else if (i_tready) begin
                r_tvalid <= 1'b0;
            end
        end
    end

    assign o_tvalid = r_tvalid;
    assign o_tdata  = r_tdata;
    assign o_tuser  = r_tuser;
    assign o_tlast  = r_tlast;

endmodule

// ===== rtl/core/base64_stream_codec.sv =====
// ----------------------------------------------------------------------------
// Base64 stream codec
// A byte that completes a job is registered as a job in the job queue, and
// its results then in the output register. Input: one byte per cycle while
// the job queue has room. Output: one result per cycle from the back end
// while the receiver takes them. Reset (synchronous, low) selects encode
// mode and empties group state, queue and output register.
// ----------------------------------------------------------------------------
module base64_stream_codec
    import b64c_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_mode_we,
    input  logic       i_mode_wdata,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [1:0] m_axis_tuser,   // [0] has_data, [1] bad_length
    output logic       m_axis_tlast
);

    logic q_full;
    logic q_push;
    logic q_valid;
    logic q_pop;
    t_job f_job;
    t_job q_job;

    b64c_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_mode_we    (i_mode_we),
        .i_mode_wdata (i_mode_wdata),
        .i_valid      (s_axis_tvalid),
        .i_data       (s_axis_tdata),
        .i_last       (s_axis_tlast),
        .i_full       (q_full),
        .o_ready      (s_axis_tready),
        .o_push       (q_push),
        .o_job        (f_job)
    );

    b64c_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (f_job),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    b64c_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_job    (q_job),
        .o_pop    (q_pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser),
        .o_tlast  (m_axis_tlast)
    );

endmodule

// ===== test/base64_stream_codec_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 stream codec checker
// Watches the mode write port and both stream channels, predicts the results
// of every accepted input transaction and compares each output transaction
// against the oldest prediction.
// ----------------------------------------------------------------------------
module base64_stream_codec_check
    import b64c_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_mode_we,
    input  logic       i_mode_wdata,
    input  logic       i_s_tvalid,
    input  logic       i_s_tready,
    input  logic [7:0] i_s_tdata,
    input  logic       i_s_tlast,
    input  logic       i_m_tvalid,
    input  logic       i_m_tready,
    input  logic [7:0] i_m_tdata,
    input  logic [1:0] i_m_tuser,
    input  logic       i_m_tlast,
    output int         o_pending,
    output int         o_errors
);

    localparam logic [511:0] ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef struct packed {
        logic [7:0] data;
        logic       has_data;
        logic       bad_length;
        logic       eom;
    } t_codec_result;

    t_codec_result expected_q[$];
    int            error_count = 0;

    // predicted codec state
    logic          mode_q  = MODE_ENCODE;
    logic [1:0]    phase_q = 2'd0;
    logic [23:0]   held_q  = 24'd0;
    logic [1:0]    pads_q  = 2'd0;

    function automatic logic [7:0] symbol_of(input logic [5:0] idx);
        return ALPHABET[8 * (63 - idx) +: 8];
    endfunction

    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        for (int k = 0; k < 64; k++) begin
            if (symbol_of(k[5:0]) == c) begin
                return k[6:0];
            end
        end
        if (c == CHAR_PAD) begin
            return VAL_PAD;
        end
        return VAL_SKIP;
    endfunction

    task automatic clear_group();
        phase_q = 2'd0;
        held_q  = 24'd0;
        pads_q  = 2'd0;
    endtask

    task automatic predict_item(input logic [7:0] b, input logic last);
        t_codec_result res[$];
        logic [23:0]   bits;
        logic [6:0]    val;
        if (mode_q == MODE_ENCODE) begin
            held_q  = {held_q[15:0], b};
            phase_q = phase_q + 2'd1;
            if (phase_q == 2'd3) begin
                for (int k = 3; k >= 0; k--) begin
                    res.push_back('{symbol_of(held_q[6 * k +: 6]), 1'b1, 1'b0, 1'b0});
                end
                clear_group();
            end else if (last) begin
                bits = (phase_q == 2'd1) ? {held_q[7:0], 16'h0} : {held_q[15:0], 8'h0};
                res.push_back('{symbol_of(bits[23:18]), 1'b1, 1'b0, 1'b0});
                res.push_back('{symbol_of(bits[17:12]), 1'b1, 1'b0, 1'b0});
                if (phase_q == 2'd1) begin
                    res.push_back('{CHAR_PAD, 1'b1, 1'b0, 1'b0});
                end else begin
                    res.push_back('{symbol_of(bits[11:6]), 1'b1, 1'b0, 1'b0});
                end
                res.push_back('{CHAR_PAD, 1'b1, 1'b0, 1'b0});
                clear_group();
            end
        end else begin
            val = sextet_of(b);
            if (val != VAL_SKIP) begin
                // a pad counts as zero bits and trims one byte from its group
                if (val == VAL_PAD) begin
                    val = 7'd0;
                    if (pads_q != 2'd3) begin
                        pads_q = pads_q + 2'd1;
                    end
                end
                held_q = {held_q[17:0], val[5:0]};
                if (phase_q == 2'd3) begin
                    for (int k = 0; k < 3 - pads_q; k++) begin
                        res.push_back('{held_q[8 * (2 - k) +: 8], 1'b1, 1'b0, 1'b0});
                    end
                    clear_group();
                end else begin
                    phase_q = phase_q + 2'd1;
                end
            end
            if (last) begin
                if (phase_q != 2'd0) begin
                    res.push_back('{8'h00, 1'b0, 1'b1, 1'b0});
                    clear_group();
                end else if (res.size() == 0) begin
                    res.push_back('{8'h00, 1'b0, 1'b0, 1'b0});
                end
            end
        end
        if (last && res.size() > 0) begin
            res[res.size() - 1].eom = 1'b1;
        end
        foreach (res[k]) begin
            expected_q.push_back(res[k]);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_codec_result got;
        t_codec_result want;
        if (!i_rst_n) begin
            mode_q = MODE_ENCODE;
            clear_group();
            expected_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got = '{i_m_tdata, i_m_tuser[0], i_m_tuser[1], i_m_tlast};
                if (expected_q.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result data %02h has %0b bad %0b last %0b",
                             $time, got.data, got.has_data, got.bad_length, got.eom);
                end else begin
                    want = expected_q.pop_front();
                    if (got.data !== want.data || got.has_data !== want.has_data ||
                        got.bad_length !== want.bad_length || got.eom !== want.eom) begin
                        error_count++;
                        $display("%0t: mismatch expected data %02h has %0b bad %0b last %0b",
                                 $time, want.data, want.has_data, want.bad_length, want.eom);
                        $display("%0t:          actual   data %02h has %0b bad %0b last %0b",
                                 $time, got.data, got.has_data, got.bad_length, got.eom);
                    end
                end
            end
            // a mode write drops any partial group
            if (i_mode_we) begin
                mode_q = i_mode_wdata;
                clear_group();
            end
            if (i_s_tvalid && i_s_tready) begin
                predict_item(i_s_tdata, i_s_tlast);
            end
        end
        o_pending <= expected_q.size();
        o_errors  <= error_count;
    end

endmodule

// ===== test/base64_stream_codec_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 stream codec regression
// Directed messages in both modes, then random encode and decode messages
// across several sender and receiver stall profiles, checked by the checker.
// ----------------------------------------------------------------------------
module base64_stream_codec_test;
    import b64c_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASE_ITEMS   = 25;

    localparam logic [511:0] ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_mode_we     = 1'b0;
    logic       i_mode_wdata  = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;   // [7:0] data_byte
    logic       s_axis_tlast  = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;            // [7:0] out_byte
    logic [1:0] m_axis_tuser;            // [0] has_data, [1] bad_length
    logic       m_axis_tlast;

    int pending;
    int errors;
    int cycle_count    = 0;
    int items_sent     = 0;
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;

    base64_stream_codec u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_mode_we     (i_mode_we),
        .i_mode_wdata  (i_mode_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    base64_stream_codec_check u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_mode_we    (i_mode_we),
        .i_mode_wdata (i_mode_wdata),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tlast    (s_axis_tlast),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .i_m_tlast    (m_axis_tlast),
        .o_pending    (pending),
        .o_errors     (errors)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("base64_stream_codec regression: fail");
            $finish;
        end
    end

    function automatic logic [7:0] random_symbol();
        return ALPHABET[8 * (63 - $urandom_range(63)) +: 8];
    endfunction

    // characters the decoder skips
    function automatic logic [7:0] noise_byte();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'h0A;
            2: return 8'h0D;
            3: return 8'h20;
            4: return 8'h2A;
            5: return 8'h7F;
            6: return 8'h80;
            default: return 8'hFF;
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        items_sent++;
    endtask

    task automatic send_text(input string s, input logic close);
        for (int k = 0; k < s.len(); k++) begin
            send_byte(s[k], close && (k == s.len() - 1));
        end
    endtask

    // hold until every predicted result is out, then let the block settle
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_mode(input logic mode_sel);
        wait_idle();
        i_mode_we    <= 1'b1;
        i_mode_wdata <= mode_sel;
        @(posedge i_clk);
        i_mode_we    <= 1'b0;
    endtask

    task automatic send_encode_message();
        int len;
        len = $urandom_range(1, 12);
        for (int k = 0; k < len; k++) begin
            send_byte(8'($urandom_range(255)), k == len - 1);
        end
    endtask

    task automatic send_decode_message();
        int         kind;
        int         groups;
        int         npad;
        int         len;
        logic       tail_noise;
        logic [7:0] c;
        kind = $urandom_range(99);
        if (kind < 70) begin
            // well-formed groups, optional padding, skipped characters mixed in
            groups     = $urandom_range(1, 3);
            npad       = $urandom_range(0, 2);
            tail_noise = ($urandom_range(9) == 0);
            for (int g = 0; g < groups; g++) begin
                for (int k = 0; k < 4; k++) begin
                    if ($urandom_range(9) == 0) begin
                        send_byte(noise_byte(), 1'b0);
                    end
                    c = (g == groups - 1 && k >= 4 - npad) ? CHAR_PAD : random_symbol();
                    send_byte(c, !tail_noise && g == groups - 1 && k == 3);
                end
            end
            if (tail_noise) begin
                send_byte(noise_byte(), 1'b1);
            end
        end else if (kind < 85) begin
            // length that stops inside a group
            len = 4 * $urandom_range(0, 2) + $urandom_range(1, 3);
            for (int k = 0; k < len; k++) begin
                send_byte(random_symbol(), k == len - 1);
            end
        end else begin
            len = $urandom_range(1, 8);
            for (int k = 0; k < len; k++) begin
                c = ($urandom_range(3) == 0) ? CHAR_PAD : 8'($urandom_range(255));
                send_byte(c, k == len - 1);
            end
        end
    endtask

    initial begin
        logic mode_sel;
        int   target;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // encode: one and two leftover bytes, then a full group
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hA5, 1'b1);

        set_mode(MODE_DECODE);
        send_text("/+9", 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte("z", 1'b1);
        // all pads: no bytes, bare terminator
        send_text("====", 1'b1);
        // message ending inside a group
        send_text("Zg", 1'b1);
        // pads away from the end, then a skipped character closes the message
        send_text("=A==", 1'b0);
        send_byte(8'h00, 1'b1);
        // partial group dropped by the mode write
        send_text("AB", 1'b0);
        set_mode(MODE_ENCODE);

        for (int p = 0; p < 8; p++) begin
            mode_sel = (p % 2 == 1) ? MODE_DECODE : MODE_ENCODE;
            set_mode(mode_sel);
            case (p / 2)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 62; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 62; end
                default: begin src_idle_pct = 6; sink_stall_pct = 6; end
            endcase
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) begin
                if (mode_sel == MODE_ENCODE) begin
                    send_encode_message();
                end else begin
                    send_decode_message();
                end
            end
            // leave a partial group for the next mode write to drop
            if ($urandom_range(3) == 0) begin
                for (int k = $urandom_range(1, 2); k > 0; k--) begin
                    send_byte((mode_sel == MODE_ENCODE) ? 8'($urandom_range(255))
                                                        : random_symbol(), 1'b0);
                end
            end
        end

        wait_idle();
        if (errors == 0) begin
            $display("base64_stream_codec regression: pass");
        end else begin
            $display("base64_stream_codec regression: fail");
        end
        $finish;
    end

endmodule
